// ===== src/pcrm_pkg.sv =====
// Package: shared constants, types and state encodings for the port counter rate meter.
package pcrm_pkg;

   localparam int MaxPorts   = 64;
   localparam int SlotWidth  = $clog2(MaxPorts);
   localparam int CountWidth = 7;
   localparam int PortWidth  = 32;
   localparam int CtrWidth   = 64;
   localparam int TimeWidth  = 32;
   localparam int RateWidth  = 32;
   localparam int CsrAddrWidth = 1;
   localparam int CsrDataWidth = 7;
   localparam int DivCntWidth  = $clog2(CtrWidth + 1);

   // Slot memory row: counters and times.
   localparam int RowWidth = 4 * CtrWidth + 2 * TimeWidth;

   localparam logic [CsrAddrWidth-1:0] CsrTimeSource = 1'd0;
   localparam logic [CsrAddrWidth-1:0] CsrPortCount  = 1'd1;

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdStats = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH,
      ST_READ,
      ST_CHECK,
      ST_DIVIDE,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic search_start;
      logic search_step;
      logic mem_read;
      logic div_start;
      logic div_step;
      logic update_write;
      logic set_fresh;
      logic set_found;
      logic set_updated;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic is_stats;
      logic search_done;
      logic search_hit;
      logic interval_zero;
      logic seen;
      logic div_done;
   } status_type;

   typedef struct packed {
      logic                 found;
      logic                 updated;
      logic                 rates_fresh;
      logic [SlotWidth-1:0] hit_slot;
      logic [RateWidth-1:0] rx_byte_rate;
      logic [RateWidth-1:0] tx_byte_rate;
      logic [RateWidth-1:0] rx_packet_rate;
      logic [RateWidth-1:0] tx_packet_rate;
   } rsp_type;

   typedef struct packed {
      logic                 cmd;
      logic [5:0]           slot;
      logic [PortWidth-1:0] port_number;
      logic [CtrWidth-1:0]  rx_packet_count;
      logic [CtrWidth-1:0]  tx_packet_count;
      logic [CtrWidth-1:0]  rx_byte_count;
      logic [CtrWidth-1:0]  tx_byte_count;
      logic [TimeWidth-1:0] now_sec;
      logic [TimeWidth-1:0] uptime_sec;
   } req_type;

endpackage

// ===== src/pcrm_if.sv =====
// Interface: valid/ready channel carrying one payload item.
interface pcrm_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pcrm_ram.sv =====
// Generic RAM with one write port, one read port and registered read.
module pcrm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/pcrm_ctrl.sv =====
// Controller: sequences load, search, lookup, division and result for one item.
module pcrm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pcrm_pkg::status_type  status,
   output pcrm_pkg::cmd_type     cmd
);
   pcrm_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcrm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         pcrm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = pcrm_pkg::ST_LOAD;
            end
         end
         pcrm_pkg::ST_LOAD: begin
            if (status.is_stats) begin
               cmd.search_start = 1'b1;
               state_in = pcrm_pkg::ST_SEARCH;
            end else begin
               cmd.load_write = 1'b1;
               state_in = pcrm_pkg::ST_OUT;
            end
         end
         pcrm_pkg::ST_SEARCH: begin
            if (status.search_hit) begin
               cmd.mem_read = 1'b1;
               cmd.set_found = 1'b1;
               state_in = pcrm_pkg::ST_READ;
            end else if (status.search_done) begin
               state_in = pcrm_pkg::ST_OUT;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         pcrm_pkg::ST_READ: begin
            state_in = pcrm_pkg::ST_CHECK;
         end
         pcrm_pkg::ST_CHECK: begin
            if (status.interval_zero) begin
               state_in = pcrm_pkg::ST_OUT;
            end else if (status.seen) begin
               cmd.div_start = 1'b1;
               cmd.set_fresh = 1'b1;
               state_in = pcrm_pkg::ST_DIVIDE;
            end else begin
               state_in = pcrm_pkg::ST_WRITE;
            end
         end
         pcrm_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = pcrm_pkg::ST_WRITE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         pcrm_pkg::ST_WRITE: begin
            cmd.update_write = 1'b1;
            cmd.set_updated  = 1'b1;
            state_in = pcrm_pkg::ST_OUT;
         end
         pcrm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = pcrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcrm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== src/pcrm_datapath.sv =====
// Datapath: port table, slot memory, seen flags, search counter and shared divider.
module pcrm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pcrm_pkg::cmd_type                 cmd,
   output pcrm_pkg::status_type              status,
   input  pcrm_pkg::req_type                 req_payload,
   output pcrm_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [pcrm_pkg::CsrAddrWidth-1:0] csr_index,
   input  logic [pcrm_pkg::CsrDataWidth-1:0] csr_write_data
);
   localparam int SW = pcrm_pkg::SlotWidth;
   localparam int CW = pcrm_pkg::CtrWidth;
   localparam int TW = pcrm_pkg::TimeWidth;
   localparam int RW = pcrm_pkg::RateWidth;
   localparam int NW = pcrm_pkg::CountWidth;
   localparam int DW = pcrm_pkg::DivCntWidth;

   pcrm_pkg::req_type req_ff;
   pcrm_pkg::rsp_type rsp_ff, rsp_in;
   logic              time_source_ff;
   logic [NW-1:0]     port_count_ff;

   logic [pcrm_pkg::MaxPorts-1:0] seen_ff;
   logic [pcrm_pkg::MaxPorts-1:0] valid_ff;
   logic [SW:0]                   idx_ff;
   logic [NW-1:0]                 limit;
   logic                          found_ff, updated_ff, fresh_ff;
   logic [SW-1:0]                 hit_ff;

   logic                       id_wr;
   logic [pcrm_pkg::PortWidth-1:0] id_rd;
   logic                       id_valid_q_ff;
   logic                       idx_live_q_ff;
   logic [SW-1:0]              idx_q_ff;

   logic                        row_wr;
   logic [pcrm_pkg::RowWidth-1:0] row_wdata, row_rd;
   logic [CW-1:0] last_rxp, last_txp, last_rxb, last_txb;
   logic [TW-1:0] last_clk, last_up, interval;

   logic [CW-1:0] dvd_ff [4];
   logic [CW-1:0] rem_ff [4];
   logic [TW-1:0] divisor_ff;
   logic [DW-1:0] div_cnt_ff;
   logic [CW-1:0] cur_ctr [4];
   logic [CW-1:0] old_ctr [4];
   logic [RW-1:0] rate [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_source_ff <= 1'b0;
         port_count_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pcrm_pkg::CsrTimeSource: time_source_ff <= csr_write_data[0];
            pcrm_pkg::CsrPortCount:  port_count_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign id_wr   = cmd.load_write && ({1'b0, req_ff.slot} < (SW+1)'(pcrm_pkg::MaxPorts));

   // an update also writes the matching port number, so the slot stays valid
   pcrm_ram #(.Width(pcrm_pkg::PortWidth), .Depth(pcrm_pkg::MaxPorts)) u_id_ram (
      .clock  (clock),
      .wr_en  (id_wr || cmd.update_write),
      .wr_addr(id_wr ? req_ff.slot[SW-1:0] : hit_ff),
      .wr_data(req_ff.port_number),
      .rd_addr(idx_ff[SW-1:0]),
      .rd_data(id_rd)
   );

   assign row_wr = id_wr || cmd.update_write;
   assign row_wdata = id_wr ? '0 : {req_ff.rx_packet_count, req_ff.tx_packet_count,
                                    req_ff.rx_byte_count, req_ff.tx_byte_count,
                                    req_ff.now_sec, req_ff.uptime_sec};

   pcrm_ram #(.Width(pcrm_pkg::RowWidth), .Depth(pcrm_pkg::MaxPorts)) u_row_ram (
      .clock  (clock),
      .wr_en  (row_wr),
      .wr_addr(id_wr ? req_ff.slot[SW-1:0] : hit_ff),
      .wr_data(row_wdata),
      .rd_addr(hit_ff),
      .rd_data(row_rd)
   );

   assign {last_rxp, last_txp, last_rxb, last_txb, last_clk, last_up} =
      valid_ff[hit_ff] ? row_rd : '0;
   assign interval = time_source_ff ? (req_ff.uptime_sec - last_up)
                                    : (req_ff.now_sec - last_clk);

   assign limit = (port_count_ff > NW'(pcrm_pkg::MaxPorts)) ? NW'(pcrm_pkg::MaxPorts)
                                                           : port_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         seen_ff       <= '0;
         idx_ff        <= '0;
         id_valid_q_ff <= 1'b0;
         idx_live_q_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            req_ff <= req_payload;
         end
         if (id_wr) begin
            valid_ff[req_ff.slot[SW-1:0]] <= 1'b1;
            seen_ff[req_ff.slot[SW-1:0]]  <= 1'b0;
         end
         if (cmd.update_write) begin
            valid_ff[hit_ff] <= 1'b1;
            seen_ff[hit_ff]  <= 1'b1;
         end
         if (cmd.search_start) begin
            idx_ff        <= '0;
            idx_live_q_ff <= 1'b0;
         end else if (cmd.search_step) begin
            idx_live_q_ff <= (NW'(idx_ff) < limit);
            id_valid_q_ff <= valid_ff[idx_ff[SW-1:0]];
            idx_q_ff      <= idx_ff[SW-1:0];
            if (NW'(idx_ff) < limit) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // slot-valid flags reset to zero: an unwritten slot reads as port 0
   assign status.search_hit  = idx_live_q_ff &&
      ((id_valid_q_ff ? id_rd : '0) == req_ff.port_number);
   assign status.search_done = !idx_live_q_ff && (NW'(idx_ff) >= limit);
   assign status.is_stats      = (req_ff.cmd == pcrm_pkg::CmdStats);
   assign status.interval_zero = (interval == '0);
   assign status.seen          = seen_ff[hit_ff];
   assign status.div_done      = (div_cnt_ff == '0);

   assign cur_ctr[0] = req_ff.rx_byte_count;   assign old_ctr[0] = last_rxb;
   assign cur_ctr[1] = req_ff.tx_byte_count;   assign old_ctr[1] = last_txb;
   assign cur_ctr[2] = req_ff.rx_packet_count; assign old_ctr[2] = last_rxp;
   assign cur_ctr[3] = req_ff.tx_packet_count; assign old_ctr[3] = last_txp;

   // restoring division, one quotient bit per cycle on four lanes
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [CW:0] trial;
      assign trial = {rem_ff[l], dvd_ff[l][CW-1]} - {{(CW+1-TW){1'b0}}, divisor_ff};
      always_ff @(posedge clock) begin
         if (cmd.div_start) begin
            dvd_ff[l] <= cur_ctr[l] - old_ctr[l];
            rem_ff[l] <= '0;
         end else if (cmd.div_step) begin
            if (!trial[CW]) begin
               rem_ff[l] <= trial[CW-1:0];
               dvd_ff[l] <= {dvd_ff[l][CW-2:0], 1'b1};
            end else begin
               rem_ff[l] <= {rem_ff[l][CW-2:0], dvd_ff[l][CW-1]};
               dvd_ff[l] <= {dvd_ff[l][CW-2:0], 1'b0};
            end
         end
      end
      assign rate[l] = (dvd_ff[l][CW-1:RW] != '0) ? '1 : dvd_ff[l][RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
         found_ff   <= 1'b0;
         updated_ff <= 1'b0;
         fresh_ff   <= 1'b0;
         hit_ff     <= '0;
      end else begin
         if (cmd.capture) begin
            found_ff   <= 1'b0;
            updated_ff <= 1'b0;
            fresh_ff   <= 1'b0;
            hit_ff     <= '0;
         end
         if (cmd.set_found) begin
            found_ff <= 1'b1;
            hit_ff   <= idx_q_ff;
         end
         if (cmd.set_fresh)   fresh_ff   <= 1'b1;
         if (cmd.set_updated) updated_ff <= 1'b1;
         if (cmd.div_start) begin
            divisor_ff <= interval;
            div_cnt_ff <= DW'(CW);
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.found       = found_ff;
      rsp_in.updated     = updated_ff;
      rsp_in.rates_fresh = fresh_ff;
      rsp_in.hit_slot    = hit_ff;
      if (fresh_ff) begin
         rsp_in.rx_byte_rate   = rate[0];
         rsp_in.tx_byte_rate   = rate[1];
         rsp_in.rx_packet_rate = rate[2];
         rsp_in.tx_packet_rate = rate[3];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;
endmodule

// ===== src/port_counter_rate_meter_unit.sv =====
// Top level: port counter rate meter with valid/ready item channels.
// From acceptance to result: a load item writes its slot; a stats item scans min(port_count,64)
// slots, and on a match reads the slot row and, with rates, runs the four-lane bit-serial divider
// before the result is offered; the result waits while the output stalls.
// One item in flight; the next is taken once the result register is loaded.
// Synchronous reset clears control state, CSRs, status, seen and slot-valid flags at once.
module port_counter_rate_meter_unit (
   input logic                                 clock,
   input logic                                 reset,
   pcrm_if.sink                                req,
   pcrm_if.source                              rsp,
   input logic                                 csr_write_enable,
   input logic [pcrm_pkg::CsrAddrWidth-1:0]    csr_index,
   input logic [pcrm_pkg::CsrDataWidth-1:0]    csr_write_data
);
   pcrm_pkg::cmd_type    cmd;
   pcrm_pkg::status_type status;

   pcrm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .status   (status),
      .cmd      (cmd)
   );

   pcrm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_payload     (req.payload),
      .rsp_payload     (rsp.payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   a_one_way: assert property (@(posedge clock) disable iff (reset)
      !(cmd.update_write && cmd.load_write))
      else $error("update and load write together");
   a_fresh_found: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (!rsp.payload.rates_fresh || rsp.payload.updated))
      else $error("fresh rates without update");
   a_upd_found: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (!rsp.payload.updated || rsp.payload.found))
      else $error("update without match");
endmodule
